FILE: sv/tcs_pkg.sv
package tcs_pkg;

  // Screen geometry
  localparam int COLUMNS = 80;
  localparam int ROWS    = 25;
  localparam int CELLS   = ROWS * COLUMNS;

  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int FILL_W = $clog2(COLUMNS + 1);
  localparam int ADDR_W = $clog2(CELLS);

  // Port field widths
  localparam int CELL_W        = 16;
  localparam int ATTR_W        = 8;
  localparam int CHAR_W        = 8;
  localparam int COLOR_W       = 4;
  localparam int ROW_FIELD_W   = 5;
  localparam int COL_FIELD_W   = 7;
  localparam int CFG_INDEX_W   = 1;
  localparam int CFG_DATA_W    = COLOR_W;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [CHAR_W-1:0] CHAR_LINE_FEED       = 8'd10;
  localparam logic [CHAR_W-1:0] CHAR_CARRIAGE_RETURN = 8'd13;
  localparam logic [CHAR_W-1:0] CHAR_SPACE           = 8'h20;

  localparam logic [COLOR_W-1:0] FG_RESET   = 4'd7;
  localparam logic [COLOR_W-1:0] BG_RESET   = 4'd0;
  localparam logic [ATTR_W-1:0]  ATTR_RESET = {BG_RESET, FG_RESET};

  localparam logic OPCODE_PUT  = 1'b0;
  localparam logic OPCODE_READ = 1'b1;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_FOREGROUND = 1'b0,
    REG_BACKGROUND = 1'b1
  } cfg_reg_e;

  typedef enum logic [1:0] {
    OP_PUT,
    OP_LINE_FEED,
    OP_CARRIAGE_RETURN,
    OP_READ
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RD_ADDR,
    ST_RD_DATA
  } state_e;

  typedef struct packed {
    logic                   opcode;
    logic [CHAR_W-1:0]      char_code;
    logic [ROW_FIELD_W-1:0] read_row;
    logic [COL_FIELD_W-1:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [CELL_W-1:0]      cell_data;
    logic [ROW_FIELD_W-1:0] cursor_row;
    logic [COL_FIELD_W-1:0] cursor_column;
    logic                   scrolled;
  } out_item_t;

  // Classified command held in the queue
  typedef struct packed {
    op_e               op;
    logic [CHAR_W-1:0] char_code;
    logic [ROW_W-1:0]  read_row;
    logic [COL_W-1:0]  read_col;
    logic              read_ok;
  } cmd_t;

endpackage

FILE: sv/tcs_ram.sv
module tcs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: sv/tcs_front.sv
module tcs_front import tcs_pkg::*; (
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  input  logic     full_i,
  output logic     push_o,
  output cmd_t     cmd_o
);

  assign in_ready_o = !full_i;
  assign push_o     = in_valid_i && !full_i;

  always_comb begin
    cmd_o.char_code = in_data_i.char_code;
    cmd_o.read_row  = ROW_W'(in_data_i.read_row);
    cmd_o.read_col  = COL_W'(in_data_i.read_column);
    // out-of-screen reads return zero
    cmd_o.read_ok   = (32'(in_data_i.read_row) < ROWS) &&
                      (32'(in_data_i.read_column) < COLUMNS);
    if (in_data_i.opcode == OPCODE_READ) begin
      cmd_o.op = OP_READ;
    end else if (in_data_i.char_code == CHAR_LINE_FEED) begin
      cmd_o.op = OP_LINE_FEED;
    end else if (in_data_i.char_code == CHAR_CARRIAGE_RETURN) begin
      cmd_o.op = OP_CARRIAGE_RETURN;
    end else begin
      cmd_o.op = OP_PUT;
    end
  end

endmodule

FILE: sv/tcs_queue.sv
module tcs_queue import tcs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  cmd_t cmd_i,
  output logic full_o,
  output logic valid_o,
  input  logic pop_i,
  output cmd_t cmd_o
);

  cmd_t              entries_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [QPTR_W:0]   count_q, count_d;

  assign full_o  = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign cmd_o   = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? wr_ptr_q + 1'b1 : wr_ptr_q;
    rd_ptr_d = pop_i  ? rd_ptr_q + 1'b1 : rd_ptr_q;
    count_d  = count_q;
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: sv/tcs_back.sv
module tcs_back import tcs_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              q_valid_i,
  input  cmd_t              q_cmd_i,
  output logic              q_pop_o,
  input  logic [ATTR_W-1:0] attr_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output out_item_t         out_data_o
);

  function automatic logic [ROW_W-1:0] row_wrap(input logic [ROW_W:0] s);
    if (32'(s) >= ROWS) begin
      return ROW_W'(s - (ROW_W+1)'(ROWS));
    end
    return ROW_W'(s);
  endfunction

  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] r,
                                                  input logic [COL_W-1:0] c);
    return ADDR_W'(r) * ADDR_W'(COLUMNS) + ADDR_W'(c);
  endfunction

  state_e state_q, state_d;

  // Cursor in screen coordinates, plus its row in the store. The store is a
  // ring of rows: top_q is the store row shown as screen row 0.
  logic [ROW_W-1:0] row_q, row_d;
  logic [COL_W-1:0] col_q, col_d;
  logic [ROW_W-1:0] cur_phys_q, cur_phys_d;
  logic [ROW_W-1:0] top_q, top_d;

  // Per store row: how many leading cells hold written data, and the
  // attribute of the blanks beyond them.
  logic [FILL_W-1:0] fill_q  [ROWS];
  logic [FILL_W-1:0] fill_d  [ROWS];
  logic [ATTR_W-1:0] blank_q [ROWS];
  logic [ATTR_W-1:0] blank_d [ROWS];

  logic [ROW_W-1:0]  rd_phys_q, rd_phys_d;
  logic [COL_W-1:0]  rd_col_q, rd_col_d;
  logic              rd_ok_q, rd_ok_d;
  logic              hit_q, hit_d;
  logic [CELL_W-1:0] blank_cell_q, blank_cell_d;

  logic              out_valid_q, out_valid_d;
  out_item_t         out_q, out_d;
  logic              out_free;
  logic              load;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  logic [CELL_W-1:0] ram_wdata, ram_rdata;

  logic [FILL_W-1:0] col_inc;
  logic              adv_row;
  logic              scrolled;

  assign out_free = !out_valid_q || out_ready_i;

  tcs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free && q_cmd_i.op == OP_READ) begin
          state_d = ST_RD_ADDR;
        end
      end
      ST_RD_ADDR: state_d = ST_RD_DATA;
      ST_RD_DATA: state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    row_d        = row_q;
    col_d        = col_q;
    cur_phys_d   = cur_phys_q;
    top_d        = top_q;
    fill_d       = fill_q;
    blank_d      = blank_q;
    rd_phys_d    = rd_phys_q;
    rd_col_d     = rd_col_q;
    rd_ok_d      = rd_ok_q;
    hit_d        = hit_q;
    blank_cell_d = blank_cell_q;
    q_pop_o      = 1'b0;
    ram_we       = 1'b0;
    ram_re       = 1'b0;
    ram_waddr    = cell_addr(cur_phys_q, col_q);
    ram_wdata    = {attr_i, q_cmd_i.char_code};
    ram_raddr    = cell_addr(rd_phys_q, rd_col_q);
    load         = 1'b0;
    out_d        = out_q;
    col_inc      = FILL_W'(col_q) + 1'b1;
    adv_row      = 1'b0;
    scrolled     = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o = 1'b1;
          case (q_cmd_i.op)
            OP_READ: begin
              rd_phys_d = row_wrap((ROW_W+1)'(q_cmd_i.read_row) + (ROW_W+1)'(top_q));
              rd_col_d  = q_cmd_i.read_col;
              rd_ok_d   = q_cmd_i.read_ok;
            end
            OP_PUT: begin
              ram_we = 1'b1;
              if (col_inc > fill_q[cur_phys_q]) begin
                fill_d[cur_phys_q] = col_inc;
              end
              if (col_inc == FILL_W'(COLUMNS)) begin
                col_d   = '0;
                adv_row = 1'b1;
              end else begin
                col_d = COL_W'(col_inc);
              end
            end
            OP_LINE_FEED: begin
              col_d   = '0;
              adv_row = 1'b1;
            end
            default: begin
              col_d = '0;
            end
          endcase
          if (adv_row) begin
            if (row_q == ROW_W'(ROWS - 1)) begin
              // scroll: the old top row becomes the new, blank bottom row
              scrolled            = 1'b1;
              top_d               = row_wrap((ROW_W+1)'(top_q) + 1'b1);
              cur_phys_d          = top_q;
              fill_d[top_q]       = '0;
              blank_d[top_q]      = attr_i;
            end else begin
              row_d      = row_q + 1'b1;
              cur_phys_d = row_wrap((ROW_W+1)'(cur_phys_q) + 1'b1);
            end
          end
          if (q_cmd_i.op != OP_READ) begin
            load                = 1'b1;
            out_d.cell_data     = '0;
            out_d.cursor_row    = ROW_FIELD_W'(row_d);
            out_d.cursor_column = COL_FIELD_W'(col_d);
            out_d.scrolled      = scrolled;
          end
        end
      end
      ST_RD_ADDR: begin
        ram_re       = rd_ok_q;
        hit_d        = rd_ok_q && (FILL_W'(rd_col_q) < fill_q[rd_phys_q]);
        blank_cell_d = {blank_q[rd_phys_q], CHAR_SPACE};
      end
      ST_RD_DATA: begin
        load                = 1'b1;
        out_d.cell_data     = !rd_ok_q ? '0 : (hit_q ? ram_rdata : blank_cell_q);
        out_d.cursor_row    = ROW_FIELD_W'(row_q);
        out_d.cursor_column = COL_FIELD_W'(col_q);
        out_d.scrolled      = 1'b0;
      end
      default: ;
    endcase

    if (load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      cur_phys_q  <= '0;
      top_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < ROWS; i++) begin
        fill_q[i]  <= '0;
        blank_q[i] <= ATTR_RESET;
      end
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      cur_phys_q  <= cur_phys_d;
      top_q       <= top_d;
      out_valid_q <= out_valid_d;
      fill_q      <= fill_d;
      blank_q     <= blank_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_phys_q    <= rd_phys_d;
    rd_col_q     <= rd_col_d;
    rd_ok_q      <= rd_ok_d;
    hit_q        <= hit_d;
    blank_cell_q <= blank_cell_d;
    out_q        <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

FILE: sv/text_console_cursor_scroll_unit.sv
// Text console: a 25 x 80 screen of 16-bit cells (attribute high byte,
// character low byte) and a cursor.
// Input channel (in_valid_i/in_ready_o/in_data_i) takes put and read
// transactions; output channel (out_valid_o/out_ready_i/out_data_o) gives one
// result per input, in order, with the cursor after the item and a scroll flag.
// The config port writes the foreground (index 0) and background (index 1)
// colours; write only while no transaction is in flight.
// Puts, line feeds and carriage returns pass the queue and output registers;
// reads also pass the address step and the registered memory read port. Puts
// sustain one per cycle while out_ready_i is high; a read holds later items
// until its result loads. Scrolls cost nothing extra: rows form a ring in the
// memory and a per-row fill count makes the new bottom row read as blanks.
// A two-entry queue sits between input classification and execution, so the
// input keeps accepting while a result waits; when the receiver stalls, the
// result holds and the queue fills, then in_ready_o drops.
// Reset: cursor at row 0 column 0, colours grey on black, every cell reads
// as 0x0720. No clearing pass is needed, the block is ready straight away.
module text_console_cursor_scroll_unit import tcs_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  in_item_t               in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output out_item_t              out_data_o,
  input  logic                   cfg_we_i,
  input  logic [CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [CFG_DATA_W-1:0]  cfg_data_i
);

  logic [COLOR_W-1:0] fg_q;
  logic [COLOR_W-1:0] bg_q;

  logic full;
  logic push;
  cmd_t push_cmd;
  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fg_q <= FG_RESET;
      bg_q <= BG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_index_i))
        REG_FOREGROUND: fg_q <= cfg_data_i;
        REG_BACKGROUND: bg_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  tcs_front u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .full_i     (full),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  tcs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .valid_o (q_valid),
    .pop_i   (q_pop),
    .cmd_o   (q_cmd)
  );

  tcs_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_cmd_i     (q_cmd),
    .q_pop_o     (q_pop),
    .attr_i      ({bg_q, fg_q}),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

FILE: test/text_console_cursor_scroll_unit_tb.sv
`timescale 1ns / 100ps

module text_console_cursor_scroll_unit_tb;
  import tcs_pkg::*;

  localparam int PHASES = 8;

  logic                   clk_i       = 1'b0;
  logic                   rst_ni      = 1'b0;
  logic                   in_valid_i  = 1'b0;
  logic                   in_ready_o;
  in_item_t               in_data_i   = '0;
  logic                   out_valid_o;
  logic                   out_ready_i = 1'b0;
  out_item_t              out_data_o;
  logic                   cfg_we_i    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index_i = '0;
  logic [CFG_DATA_W-1:0]  cfg_data_i  = '0;

  text_console_cursor_scroll_unit u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_data_o (out_data_o),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Console image kept alongside the block
  logic [CELL_W-1:0]  screen_image [ROWS][COLUMNS];
  int                 cursor_row_m;
  int                 cursor_col_m;
  logic [COLOR_W-1:0] fg_color;
  logic [COLOR_W-1:0] bg_color;

  in_item_t  pending_items[$];
  out_item_t expected_results[$];
  int        items_total  = 0;
  int        results_seen = 0;
  int        err_count    = 0;
  bit        in_fire      = 1'b0;

  int burst_left  = 8;
  int gap_left    = 0;
  int cycle_count = 0;
  int hold_left   = 0;
  bit hold_done   = 1'b0;

  // Line feed per cent for each random phase: long lines after the busy ones
  // so that wraps also happen on the bottom row.
  int lf_plan [PHASES] = '{10, 0, 25, 3, 15, 1, 40, 2};
  // Colour settings per phase, -1 picks at random
  int fg_plan [PHASES] = '{15, 0, -1, 15, 0, -1, -1, 7};
  int bg_plan [PHASES] = '{15, 0, -1, 0, 15, -1, -1, 0};

  function automatic logic [CELL_W-1:0] coloured_cell(logic [CHAR_W-1:0] code);
    return {bg_color, fg_color, code};
  endfunction

  // Move the cursor down one row, scrolling at the bottom; returns the scroll flag
  function automatic bit advance_row();
    if (cursor_row_m + 1 >= ROWS) begin
      cursor_row_m = ROWS - 1;
      for (int r = 0; r < ROWS - 1; r++)
        for (int c = 0; c < COLUMNS; c++)
          screen_image[r][c] = screen_image[r+1][c];
      for (int c = 0; c < COLUMNS; c++)
        screen_image[ROWS-1][c] = coloured_cell(CHAR_SPACE);
      return 1'b1;
    end
    cursor_row_m++;
    return 1'b0;
  endfunction

  function automatic out_item_t console_advance(in_item_t it);
    out_item_t res;
    res = '0;
    if (it.opcode == OPCODE_READ) begin
      if (it.read_row < ROWS && it.read_column < COLUMNS)
        res.cell_data = screen_image[it.read_row][it.read_column];
    end else if (it.char_code == CHAR_CARRIAGE_RETURN) begin
      cursor_col_m = 0;
    end else if (it.char_code == CHAR_LINE_FEED) begin
      cursor_col_m = 0;
      res.scrolled = advance_row();
    end else begin
      screen_image[cursor_row_m][cursor_col_m] = coloured_cell(it.char_code);
      cursor_col_m++;
      if (cursor_col_m >= COLUMNS) begin
        cursor_col_m = 0;
        res.scrolled = advance_row();
      end
    end
    res.cursor_row    = ROW_FIELD_W'(cursor_row_m);
    res.cursor_column = COL_FIELD_W'(cursor_col_m);
    return res;
  endfunction

  function automatic in_item_t put_item(logic [CHAR_W-1:0] code);
    in_item_t it;
    it.opcode      = OPCODE_PUT;
    it.char_code   = code;
    it.read_row    = ROW_FIELD_W'($urandom_range(0, 31));
    it.read_column = COL_FIELD_W'($urandom_range(0, 127));
    return it;
  endfunction

  function automatic in_item_t read_item(int row, int col);
    in_item_t it;
    it.opcode      = OPCODE_READ;
    it.char_code   = CHAR_W'($urandom_range(0, 255));
    it.read_row    = ROW_FIELD_W'(row);
    it.read_column = COL_FIELD_W'(col);
    return it;
  endfunction

  function automatic in_item_t random_item(int lf_pct, int rd_pct);
    in_item_t it;
    int       pick;
    it   = put_item(CHAR_W'($urandom_range(0, 255)));
    pick = $urandom_range(0, 99);
    if (pick < rd_pct) begin
      it = read_item($urandom_range(0, 31), $urandom_range(0, 127));
      if ($urandom_range(0, 6) != 0) begin
        // bottom row gets blanked by scrolls, so look there often
        it.read_row    = ROW_FIELD_W'(($urandom_range(0, 2) == 0) ? ROWS - 1 :
                                      $urandom_range(0, ROWS - 1));
        it.read_column = COL_FIELD_W'($urandom_range(0, COLUMNS - 1));
      end
    end else if (pick < rd_pct + lf_pct) begin
      it.char_code = CHAR_LINE_FEED;
    end else if (pick < rd_pct + lf_pct + 3) begin
      it.char_code = CHAR_CARRIAGE_RETURN;
    end
    return it;
  endfunction

  task automatic queue_item(in_item_t it);
    pending_items.push_back(it);
    items_total++;
  endtask

  task automatic wait_drained();
    while (results_seen != items_total) @(negedge clk_i);
    // block latency margin
    repeat (6) @(negedge clk_i);
  endtask

  task automatic write_colours(logic [COLOR_W-1:0] fg, logic [COLOR_W-1:0] bg);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= REG_FOREGROUND;
    cfg_data_i  <= fg;
    fg_color     = fg;
    @(negedge clk_i);
    cfg_index_i <= REG_BACKGROUND;
    cfg_data_i  <= bg;
    bg_color     = bg;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_fire)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (pending_items.size() > 0) begin
        in_data_i  <= pending_items.pop_front();
        in_valid_i <= 1'b1;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: rotating stall patterns plus one long hold-off in mid traffic
  always @(negedge clk_i) begin
    cycle_count++;
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else if (!hold_done && results_seen >= 300) begin
      hold_done = 1'b1;
      hold_left = 120;
      out_ready_i <= 1'b0;
    end else begin
      case ((cycle_count / 250) % 4)
        0: out_ready_i <= 1'b1;
        1: out_ready_i <= 1'($urandom_range(0, 1));
        2: out_ready_i <= ($urandom_range(0, 4) != 0);
        default: out_ready_i <= (cycle_count % 8) < 5;
      endcase
    end
  end

  // Monitor: results are checked before the new transaction's prediction is queued
  always @(posedge clk_i) begin
    out_item_t exp_res;
    in_fire = rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && out_valid_o && out_ready_i) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $error("unexpected result transaction: %p", out_data_o);
        err_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data_o.cell_data !== exp_res.cell_data) begin
          $error("cell_data: expected %h, actual %h", exp_res.cell_data,
                 out_data_o.cell_data);
          err_count++;
        end
        if (out_data_o.cursor_row !== exp_res.cursor_row) begin
          $error("cursor_row: expected %0d, actual %0d", exp_res.cursor_row,
                 out_data_o.cursor_row);
          err_count++;
        end
        if (out_data_o.cursor_column !== exp_res.cursor_column) begin
          $error("cursor_column: expected %0d, actual %0d", exp_res.cursor_column,
                 out_data_o.cursor_column);
          err_count++;
        end
        if (out_data_o.scrolled !== exp_res.scrolled) begin
          $error("scrolled: expected %0b, actual %0b", exp_res.scrolled,
                 out_data_o.scrolled);
          err_count++;
        end
      end
    end
    if (in_fire)
      expected_results.push_back(console_advance(in_data_i));
  end

  initial begin
    #2ms;
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    for (int r = 0; r < ROWS; r++)
      for (int c = 0; c < COLUMNS; c++)
        screen_image[r][c] = {ATTR_RESET, CHAR_SPACE};
    cursor_row_m = 0;
    cursor_col_m = 0;
    fg_color     = FG_RESET;
    bg_color     = BG_RESET;

    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: blank screen, reads off the edge, extreme codes, CR and LF
    queue_item(read_item(0, 0));
    queue_item(read_item(ROWS - 1, COLUMNS - 1));
    queue_item(read_item(ROWS, 0));
    queue_item(read_item(0, COLUMNS));
    queue_item(read_item(31, 127));
    queue_item(put_item(8'h00));
    queue_item(put_item(8'hFF));
    queue_item(put_item("A"));
    queue_item(put_item(CHAR_CARRIAGE_RETURN));
    queue_item(put_item(8'h7F));
    queue_item(put_item(CHAR_LINE_FEED));
    queue_item(put_item(8'h80));
    queue_item(put_item(CHAR_LINE_FEED));
    queue_item(read_item(0, 0));
    queue_item(read_item(0, 1));
    queue_item(read_item(0, 2));
    queue_item(read_item(1, 0));
    queue_item(put_item(CHAR_CARRIAGE_RETURN));
    queue_item(read_item(2, 0));
    queue_item(read_item(0, 3));

    for (int p = 0; p < PHASES; p++) begin
      wait_drained();
      write_colours(COLOR_W'((fg_plan[p] < 0) ? $urandom_range(0, 15) : fg_plan[p]),
                    COLOR_W'((bg_plan[p] < 0) ? $urandom_range(0, 15) : bg_plan[p]));
      for (int i = 0; i < 135; i++)
        queue_item(random_item(lf_plan[p], 20));
    end

    wait_drained();
    repeat (10) @(negedge clk_i);
    if (err_count == 0 && expected_results.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
